[rtl/core/aes_pkg.sv]
package aes_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int NUM_KEYS = NUM_ROUNDS + 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW = 1'b1;

   typedef struct packed {
      logic [63:0] block_hi;
      logic [63:0] block_lo;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_hi;
      logic [63:0] cipher_lo;
   } rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit state sits at bits [127-8i -: 8]
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32*c -: 8];
         a1 = s[119 - 32*c -: 8];
         a2 = s[111 - 32*c -: 8];
         a3 = s[103 - 32*c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   // one step of the key expansion: round key r -> r+1
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

[rtl/core/aes128_block_encrypt.sv]
// AES-128 encryption core, fully pipelined.
// Key: write key_high (csr_index 0) and key_low (csr_index 1) through the csr_
// port while no item is in flight. Each write starts a key expansion that fills
// the round-key registers one round key per cycle; allow NUM_ROUNDS+1 cycles
// after the last key write before starting an item.
// Items: a plaintext block on req_data is taken at a clock edge where start is
// high and busy is low. busy is held low, so one block can enter every cycle.
// Results: the ciphertext appears on rsp_data with rsp_valid high for exactly
// one cycle, once the block has passed the register stage for the initial key
// add and one register stage per round. Throughput is one block per cycle, set
// by the one-round-per-stage pipeline. The receiver cannot stall; results are
// not held.
// Reset clears the pipeline valid bits and the key registers; round keys are
// unknown until a key is written.
module aes128_block_encrypt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  aes_pkg::req_type      req_data,
   output logic                  rsp_valid,
   output aes_pkg::rsp_type      rsp_data,
   input  logic                  csr_write,
   input  logic [aes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]           csr_data
);
   import aes_pkg::*;

   logic [63:0]  key_high_ff, key_low_ff;
   logic [127:0] rkey_ff [NUM_KEYS];
   logic [127:0] exp_key_ff, exp_key_in;
   logic [7:0]   rcon_ff;
   logic [3:0]   exp_cnt_ff;
   logic         exp_run_ff;

   logic [127:0] stage_ff [NUM_KEYS];
   logic         valid_ff [NUM_KEYS];

   assign busy = 1'b0;
   assign exp_key_in = next_key(exp_key_ff, rcon_ff);

   // key expansion sequencer: while running, stores round key exp_cnt each cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         exp_run_ff <= 1'b0;
         exp_cnt_ff <= '0;
      end else if (csr_write) begin
         exp_run_ff <= 1'b1;
         exp_cnt_ff <= '0;
         rcon_ff <= 8'h01;
         case (csr_index)
            CSR_KEY_HIGH: begin
               key_high_ff <= csr_data;
               exp_key_ff <= {csr_data, key_low_ff};
            end
            CSR_KEY_LOW: begin
               key_low_ff <= csr_data;
               exp_key_ff <= {key_high_ff, csr_data};
            end
            default: begin
               exp_key_ff <= {key_high_ff, key_low_ff};
            end
         endcase
      end else if (exp_run_ff) begin
         rkey_ff[exp_cnt_ff] <= exp_key_ff;
         exp_key_ff <= exp_key_in;
         rcon_ff <= xtime(rcon_ff);
         exp_cnt_ff <= exp_cnt_ff + 4'd1;
         if (exp_cnt_ff == 4'(NUM_ROUNDS)) begin
            exp_run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= start;
         for (int i = 1; i < NUM_KEYS; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      stage_ff[0] <= {req_data.block_hi, req_data.block_lo} ^ rkey_ff[0];
      for (int i = 1; i < NUM_ROUNDS; i++) begin
         stage_ff[i] <= mix_columns(sub_shift(stage_ff[i-1])) ^ rkey_ff[i];
      end
      stage_ff[NUM_ROUNDS] <= sub_shift(stage_ff[NUM_ROUNDS-1]) ^ rkey_ff[NUM_ROUNDS];
   end

   assign rsp_valid = valid_ff[NUM_ROUNDS];
   assign rsp_data.cipher_hi = stage_ff[NUM_ROUNDS][127:64];
   assign rsp_data.cipher_lo = stage_ff[NUM_ROUNDS][63:0];

endmodule
